### rtl/smsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smsd_pkg
// Shared types and constants of the sample mean and standard deviation block:
// controller states, datapath operation codes and the command/status bundles.
// ----------------------------------------------------------------------------
package smsd_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_COUNT_DEF    = 65536;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed widths.
  localparam int WORD_W      = 64;                // width of the long arithmetic
  localparam int COUNT_OUT_W = 17;                // width of the reported count
  localparam int ITER_W      = $clog2(WORD_W);    // iteration counter width
  localparam int DIV_STEPS   = WORD_W;            // variance division steps
  localparam int SQRT_STEPS  = WORD_W / 2;        // one result bit per step, two radicand bits

  typedef enum logic [3:0] {
    ST_ACC,      // take samples
    ST_SETTLE,   // last square lands in the square sum
    ST_LD_NS,    // load n * square sum
    ST_MUL_NS,
    ST_LD_SS,    // save product, load sum * sum
    ST_MUL_SS,
    ST_PREP,     // form numerator and denominator, load mean division
    ST_DIV_M,
    ST_LD_VAR,   // save mean, load variance division
    ST_DIV_V,
    ST_LD_SQ,    // load square root
    ST_SQRT,
    ST_OUT       // hand the result to the output register
  } smsd_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_NS,
    OP_LOAD_SS,
    OP_MUL_STEP,
    OP_PREP_DIV,
    OP_DIV_STEP,
    OP_LOAD_VAR,
    OP_LOAD_SQRT,
    OP_SQRT_STEP,
    OP_RESULT
  } smsd_op_e;

  typedef struct packed {
    logic     accept;  // a sample beat is taken this cycle
    smsd_op_e op;
  } smsd_cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
  } smsd_stat_t;

endpackage
`default_nettype wire

### rtl/sample_mean_and_std_dev_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_mean_and_std_dev_top
// Running mean and sample (n-1) standard deviation over sets of samples.
// ----------------------------------------------------------------------------
// Samples stream in one beat per cycle while the input is not stalled and
// are folded into a count, a sum and a sum of squares. The beat carrying
// last_sample_i closes the set: the block then stalls its input while it
// computes n*sumsq and sum*sum on a shift-add multiplier, the mean and the
// variance on a restoring divider and the floor square root.
// The result sits in an output register, so the next set streams in while it
// waits to be taken. A set of one sample reports a deviation of zero with
// deviation_valid_o low; samples beyond MAX_COUNT are dropped and flagged by
// count_overflow_o. The accumulators clear once the result is handed over.
// ----------------------------------------------------------------------------
module sample_mean_and_std_dev_top import smsd_pkg::*; #(
  parameter int MAX_COUNT    = MAX_COUNT_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // sample channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_value_i,
  input  wire logic                           last_sample_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      mean_value_o,
  output logic [SAMPLE_WIDTH-1:0]             std_deviation_o,
  output logic [COUNT_OUT_W-1:0]              sample_count_o,
  output logic                                deviation_valid_o,
  output logic                                count_overflow_o
);

  smsd_cmd_t  cmd;
  smsd_stat_t stat;

  // Sequencer: owns the input handshake and the iteration counts.
  smsd_ctrl #(
    .MAX_COUNT    (MAX_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_sample_i (last_sample_i),
    .in_stall_o    (in_stall_o),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // Datapath: accumulators, arithmetic units and the result register.
  smsd_dpath #(
    .MAX_COUNT    (MAX_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .sample_value_i    (sample_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .mean_value_o      (mean_value_o),
    .std_deviation_o   (std_deviation_o),
    .sample_count_o    (sample_count_o),
    .deviation_valid_o (deviation_valid_o),
    .count_overflow_o  (count_overflow_o)
  );

endmodule
`default_nettype wire

### rtl/smsd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smsd_ctrl
// Sequencer: accepts samples, then walks the datapath through the two
// products, the two divisions and the square root of one set.
// ----------------------------------------------------------------------------
module smsd_ctrl import smsd_pkg::*; #(
  parameter int MAX_COUNT    = MAX_COUNT_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       last_sample_i,
  output logic            in_stall_o,
  input  smsd_stat_t      stat_i,
  output smsd_cmd_t       cmd_o
);

  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int SUM_W = SAMPLE_WIDTH + CNT_W;

  smsd_state_e       state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              accept;

  assign in_stall_o = (state_q != ST_ACC);
  assign accept     = in_valid_i && (state_q == ST_ACC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    iter_d        = iter_q;
    cmd_o.accept  = accept;
    cmd_o.op      = OP_NONE;
    case (state_q)
      ST_ACC: begin
        if (accept && last_sample_i) begin
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_d = ST_LD_NS;
      end
      ST_LD_NS: begin
        cmd_o.op = OP_LOAD_NS;
        iter_d   = ITER_W'(CNT_W - 1);
        state_d  = ST_MUL_NS;
      end
      ST_MUL_NS: begin
        cmd_o.op = OP_MUL_STEP;
        iter_d   = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = ST_LD_SS;
        end
      end
      ST_LD_SS: begin
        cmd_o.op = OP_LOAD_SS;
        iter_d   = ITER_W'(SUM_W - 1);
        state_d  = ST_MUL_SS;
      end
      ST_MUL_SS: begin
        cmd_o.op = OP_MUL_STEP;
        iter_d   = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.op = OP_PREP_DIV;
        iter_d   = ITER_W'(SUM_W - 1);
        state_d  = ST_DIV_M;
      end
      ST_DIV_M: begin
        cmd_o.op = OP_DIV_STEP;
        iter_d   = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = ST_LD_VAR;
        end
      end
      ST_LD_VAR: begin
        cmd_o.op = OP_LOAD_VAR;
        iter_d   = ITER_W'(DIV_STEPS - 1);
        state_d  = ST_DIV_V;
      end
      ST_DIV_V: begin
        cmd_o.op = OP_DIV_STEP;
        iter_d   = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = ST_LD_SQ;
        end
      end
      ST_LD_SQ: begin
        cmd_o.op = OP_LOAD_SQRT;
        iter_d   = ITER_W'(SQRT_STEPS - 1);
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        iter_d   = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (stat_i.out_free) begin
          cmd_o.op = OP_RESULT;
          state_d  = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/smsd_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smsd_dpath
// Accumulators, a shared shift-add multiplier, a shared restoring divider,
// a bitwise square root and the output register.
// ----------------------------------------------------------------------------
module smsd_dpath import smsd_pkg::*; #(
  parameter int MAX_COUNT    = MAX_COUNT_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  smsd_cmd_t                           cmd_i,
  output smsd_stat_t                          stat_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      mean_value_o,
  output logic [SAMPLE_WIDTH-1:0]             std_deviation_o,
  output logic [COUNT_OUT_W-1:0]              sample_count_o,
  output logic                                deviation_valid_o,
  output logic                                count_overflow_o
);

  localparam int CNT_W  = $clog2(MAX_COUNT + 1);
  localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
  localparam int SQ_RAW = 2 * SAMPLE_WIDTH - 1 + CNT_W;
  localparam int SQ_W   = (SQ_RAW > WORD_W) ? WORD_W : SQ_RAW;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int P_W    = 2 * SAMPLE_WIDTH - 1;

  // ---------------- accumulation ----------------
  logic [CNT_W-1:0] count_q;
  logic [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]  sumsq_q;
  logic             ovf_q;
  logic [P_W-1:0]   sq_pend_q;
  logic             sq_take_q;

  logic                             full;
  logic signed [2*SAMPLE_WIDTH-1:0] sq_full;
  logic [SUM_W-1:0]                 sample_ext;
  logic                             clear;

  assign full       = (count_q == CNT_W'(MAX_COUNT));
  assign sq_full    = (2*SAMPLE_WIDTH)'(sample_value_i) * (2*SAMPLE_WIDTH)'(sample_value_i);
  assign sample_ext = {{CNT_W{sample_value_i[SAMPLE_WIDTH-1]}}, sample_value_i};
  assign clear      = (cmd_i.op == OP_RESULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sum_q     <= '0;
      sumsq_q   <= '0;
      ovf_q     <= 1'b0;
      sq_take_q <= 1'b0;
    end else begin
      sq_take_q <= cmd_i.accept && !full;
      if (clear) begin
        count_q <= '0;
        sum_q   <= '0;
        sumsq_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        if (cmd_i.accept) begin
          if (full) begin
            ovf_q <= 1'b1;
          end else begin
            count_q <= count_q + 1'b1;
            sum_q   <= sum_q + sample_ext;
          end
        end
        // square lands in the cycle after its sample
        if (sq_take_q) begin
          sumsq_q <= sumsq_q + SQ_W'(sq_pend_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sq_pend_q <= sq_full[P_W-1:0];
    end
  end

  logic             sneg;
  logic [SUM_W-1:0] smag;
  logic             two_plus;

  assign sneg     = sum_q[SUM_W-1];
  assign smag     = sneg ? (SUM_W'(0) - sum_q) : sum_q;
  assign two_plus = (count_q >= CNT_W'(2));

  // ---------------- shift-add multiplier ----------------
  logic [WORD_W-1:0] mcand_q, prod_q, nsq_q;
  logic [SUM_W-1:0]  mplier_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD_NS: begin
        mcand_q  <= WORD_W'(sumsq_q);
        mplier_q <= SUM_W'(count_q);
        prod_q   <= '0;
      end
      OP_LOAD_SS: begin
        nsq_q    <= prod_q;
        mcand_q  <= WORD_W'(smag);
        mplier_q <= smag;
        prod_q   <= '0;
      end
      OP_MUL_STEP: begin
        if (mplier_q[0]) begin
          prod_q <= prod_q + mcand_q;
        end
        mcand_q  <= {mcand_q[WORD_W-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[SUM_W-1:1]};
      end
      default: begin
      end
    endcase
  end

  // ---------------- restoring divider ----------------
  logic [WORD_W-1:0]  num_q, dvd_q, rem_q;
  logic [DEN_W-1:0]   den_q, dvs_q;
  logic [CNT_W-1:0]   count_m1;
  logic [DEN_W-1:0]   den_w;
  logic [WORD_W:0]    rem_sh, dvs_ext, rem_diff;
  logic               ge;
  logic [SAMPLE_WIDTH-1:0] qlow;

  assign count_m1 = count_q - 1'b1;
  assign den_w    = DEN_W'(count_q) * DEN_W'(count_m1);
  assign rem_sh   = {rem_q, dvd_q[WORD_W-1]};
  assign dvs_ext  = (WORD_W + 1)'(dvs_q);
  assign ge       = (rem_sh >= dvs_ext);
  assign rem_diff = rem_sh - dvs_ext;
  assign qlow     = dvd_q[SAMPLE_WIDTH-1:0];

  logic [SAMPLE_WIDTH-1:0] mean_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_PREP_DIV: begin
        num_q <= nsq_q - prod_q;
        den_q <= den_w;
        // align the sum magnitude to the top so only SUM_W steps are needed
        dvd_q <= WORD_W'(smag) << (WORD_W - SUM_W);
        dvs_q <= DEN_W'(count_q);
        rem_q <= '0;
      end
      OP_LOAD_VAR: begin
        mean_q <= sneg ? (SAMPLE_WIDTH'(0) - qlow) : qlow;
        dvd_q  <= num_q;
        dvs_q  <= den_q;
        rem_q  <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= ge ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
        dvd_q <= {dvd_q[WORD_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  // ---------------- bitwise square root ----------------
  logic [WORD_W-1:0] rv_q, root_q, bit_q, trial;

  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD_SQRT: begin
        rv_q   <= dvd_q;
        root_q <= '0;
        bit_q  <= WORD_W'(1) << (WORD_W - 2);
      end
      OP_SQRT_STEP: begin
        if (rv_q >= trial) begin
          rv_q   <= rv_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: begin
      end
    endcase
  end

  // ---------------- output register ----------------
  logic out_valid_q;

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (clear) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      mean_value_o      <= mean_q;
      std_deviation_o   <= two_plus ? root_q[SAMPLE_WIDTH-1:0] : '0;
      sample_count_o    <= COUNT_OUT_W'(count_q);
      deviation_valid_o <= two_plus;
      count_overflow_o  <= ovf_q;
    end
  end

endmodule
`default_nettype wire
